FILE: design/bemf_pkg.sv
`timescale 1ns / 1ps

package bemf_pkg;

  // field widths fixed by the register map and result format
  localparam int GAIN_W     = 16;
  localparam int EMF_W      = 20;
  localparam int OFS_W      = 21;
  localparam int TAU_W      = 24;
  localparam int ALPHA_W    = 16;
  localparam int GAIN_FRAC  = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // default parameter values
  localparam int SPEED_BITS_DEF = 16;
  localparam int TIME_BITS_DEF  = 32;

  // longest gap that still changes alpha
  localparam int DT_CAP_LOG2 = 40;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_EMF_GAIN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EQUILIBRIUM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAU         = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 2'd3;

  // register reset values
  localparam logic [GAIN_W-1:0]        GAIN_RST   = 16'd82;
  localparam logic signed [EMF_W-1:0]  EQUIL_RST  = 20'sd0;
  localparam logic [TAU_W-1:0]         TAU_RST    = 24'd10000;
  localparam logic                     ENABLE_RST = 1'b1;

  localparam logic signed [63:0] EMF_MAX = 64'sd524287;
  localparam logic signed [63:0] EMF_MIN = -64'sd524288;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_RAW  = 6'b000010,
    ST_DIV  = 6'b000100,
    ST_MUL  = 6'b001000,
    ST_UPD  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  function automatic logic signed [EMF_W-1:0] sat_emf(input logic signed [63:0] v);
    logic signed [EMF_W-1:0] r;
    if (v > EMF_MAX) begin
      r = EMF_W'(EMF_MAX);
    end else if (v < EMF_MIN) begin
      r = EMF_W'(EMF_MIN);
    end else begin
      r = EMF_W'(v);
    end
    return r;
  endfunction

endpackage

FILE: design/back_emf_lowpass_estimator_top.sv
`timescale 1ns / 1ps
// when the filter runs, a request passes a product for the raw value, a 16-step
// restoring divide for alpha, a second product, the update and then the result;
// when the state simply takes the raw value, the result follows the raw product.
// one request at a time: in_stall stays high until the result is taken.
// synchronous active-low reset restores register defaults and clears the filter state

module back_emf_lowpass_estimator_top
  import bemf_pkg::*;
#(
  parameter int SPEED_BITS = SPEED_BITS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [SPEED_BITS-1:0] in_speed_sample,
  input  logic [TIME_BITS-1:0]         in_sample_time,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [EMF_W-1:0]      out_emf_value,
  output logic signed [OFS_W-1:0]      out_emf_offset
);

  localparam int DT_W   = (TIME_BITS > DT_CAP_LOG2) ? DT_CAP_LOG2 + 1 : TIME_BITS;
  localparam int DIV_W  = ((DT_W > TAU_W) ? DT_W : TAU_W) + 1;
  localparam int MA_W   = (SPEED_BITS > OFS_W) ? SPEED_BITS : OFS_W;
  localparam int MB_W   = ALPHA_W + 1;
  localparam int MP_W   = MA_W + MB_W;
  localparam int CNT_W  = $clog2(ALPHA_W);
  localparam logic [63:0] DT_CAP64 = 64'd1 << DT_CAP_LOG2;

  state_t state_r, state_nxt;

  logic [GAIN_W-1:0]        gain_r;
  logic signed [EMF_W-1:0]  equil_r;
  logic [TAU_W-1:0]         tau_r;
  logic                     enable_r;

  logic signed [SPEED_BITS-1:0] speed_r, speed_nxt;
  logic [TIME_BITS-1:0]         time_r, time_nxt;
  logic [TIME_BITS-1:0]         prev_time_r, prev_time_nxt;
  logic                         seen_r, seen_nxt;
  logic signed [EMF_W-1:0]      raw_r, raw_nxt;
  logic signed [EMF_W-1:0]      filt_r, filt_nxt;
  logic [DIV_W-1:0]             div_r, div_nxt;
  logic [DIV_W-1:0]             rem_r, rem_nxt;
  logic [ALPHA_W-1:0]           q_r, q_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic signed [MP_W-1:0]       prod_r, prod_nxt;

  // shared multiplier
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [MP_W-1:0] mul_p;

  logic signed [EMF_W-1:0] raw_val;
  logic [TIME_BITS-1:0]    dt;
  logic [63:0]             dt64;
  logic [DT_W-1:0]         dt_c;
  logic [TAU_W-1:0]        tau_eff;
  logic [DIV_W:0]          rem_sh;
  logic signed [OFS_W-1:0] diff;
  logic signed [MP_W:0]    upd_sum;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_emf_value  = filt_r;
  assign out_emf_offset = OFS_W'(filt_r) - OFS_W'(equil_r);

  assign diff  = OFS_W'(raw_r) - OFS_W'(filt_r);
  assign mul_p = MP_W'(mul_a) * MP_W'(mul_b);

  always_comb begin
    if (state_r == ST_MUL) begin
      mul_a = MA_W'(diff);
      mul_b = $signed({1'b0, q_r});
    end else begin
      mul_a = MA_W'(speed_r);
      mul_b = $signed({1'b0, gain_r});
    end
  end

  assign raw_val = sat_emf(64'(mul_p) >>> GAIN_FRAC);

  // wrapping tick difference, capped where alpha stops changing
  assign dt      = time_r - prev_time_r;
  assign dt64    = 64'(dt);
  assign dt_c    = (dt64 > DT_CAP64) ? DT_W'(DT_CAP64) : DT_W'(dt64);
  assign tau_eff = (tau_r == '0) ? TAU_W'(1) : tau_r;
  assign rem_sh  = {rem_r, 1'b0};

  assign upd_sum = (MP_W + 1)'(filt_r) + (MP_W + 1)'(prod_r >>> ALPHA_W);

  always_comb begin
    state_nxt     = state_r;
    speed_nxt     = speed_r;
    time_nxt      = time_r;
    prev_time_nxt = prev_time_r;
    seen_nxt      = seen_r;
    raw_nxt       = raw_r;
    filt_nxt      = filt_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    cnt_nxt       = cnt_r;
    prod_nxt      = prod_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          speed_nxt = in_speed_sample;
          time_nxt  = in_sample_time;
          state_nxt = ST_RAW;
        end
      end
      ST_RAW: begin
        prev_time_nxt = time_r;
        seen_nxt      = 1'b1;
        if (!enable_r || !seen_r || dt == '0) begin
          filt_nxt  = raw_val;
          state_nxt = ST_OUT;
        end else begin
          raw_nxt   = raw_val;
          div_nxt   = DIV_W'(tau_eff) + DIV_W'(dt_c);
          rem_nxt   = DIV_W'(dt_c);
          q_nxt     = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        // one restoring step per cycle, remainder always below the divisor
        if (rem_sh >= {1'b0, div_r}) begin
          rem_nxt = DIV_W'(rem_sh - {1'b0, div_r});
          q_nxt   = {q_r[ALPHA_W-2:0], 1'b1};
        end else begin
          rem_nxt = DIV_W'(rem_sh);
          q_nxt   = {q_r[ALPHA_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(ALPHA_W - 1)) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt  = mul_p;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        filt_nxt  = sat_emf(64'(upd_sum));
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seen_r      <= 1'b0;
      filt_r      <= '0;
      prev_time_r <= '0;
      gain_r      <= GAIN_RST;
      equil_r     <= EQUIL_RST;
      tau_r       <= TAU_RST;
      enable_r    <= ENABLE_RST;
    end else begin
      state_r     <= state_nxt;
      seen_r      <= seen_nxt;
      filt_r      <= filt_nxt;
      prev_time_r <= prev_time_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_EMF_GAIN:    gain_r   <= cfg_data[GAIN_W-1:0];
          CFG_EQUILIBRIUM: equil_r  <= $signed(cfg_data[EMF_W-1:0]);
          CFG_TAU:         tau_r    <= cfg_data[TAU_W-1:0];
          CFG_ENABLE:      enable_r <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    speed_r <= speed_nxt;
    time_r  <= time_nxt;
    raw_r   <= raw_nxt;
    div_r   <= div_nxt;
    rem_r   <= rem_nxt;
    q_r     <= q_nxt;
    cnt_r   <= cnt_nxt;
    prod_r  <= prod_nxt;
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import bemf_pkg::*;

  localparam int SPD_W         = SPEED_BITS_DEF;
  localparam int TS_W          = TIME_BITS_DEF;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 80;
  localparam int IDLE_PCT      = 36;
  localparam int SETTLE_CYCLES = 25;

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_SAMPLE,
    ROW_CHECKED
  } row_kind_t;

  typedef struct packed {
    logic signed [EMF_W-1:0] value;
    logic signed [OFS_W-1:0] offset;
  } emf_result_t;

  typedef struct packed {
    row_kind_t               kind;
    logic [CFG_IDX_W-1:0]    idx;
    logic [CFG_DATA_W-1:0]   data;
    logic signed [SPD_W-1:0] speed;
    logic [TS_W-1:0]         stamp;
    emf_result_t             typed;
  } row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [SPD_W-1:0] in_speed_sample;
  logic [TS_W-1:0]         in_sample_time;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [EMF_W-1:0] out_emf_value;
  logic signed [OFS_W-1:0] out_emf_offset;

  // register and filter state as the block should hold them
  logic [GAIN_W-1:0]       gain_mirror;
  logic signed [EMF_W-1:0] equil_mirror;
  logic [TAU_W-1:0]        tau_mirror;
  logic                    enable_mirror;
  logic                    seen_mirror;
  logic signed [EMF_W-1:0] lowpass_state;
  logic [TS_W-1:0]         prev_stamp;

  emf_result_t emf_expected_q[$];
  row_t        stimulus_rows[$];
  int          mismatch_count = 0;
  int unsigned cycle_count = 0;
  int          tx_idle_pct = IDLE_PCT;
  int          rx_idle_pct = IDLE_PCT;
  bit          hold_off_req = 1'b0;
  int          hold_left = 0;

  back_emf_lowpass_estimator_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_speed_sample (in_speed_sample),
    .in_sample_time  (in_sample_time),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_emf_value   (out_emf_value),
    .out_emf_offset  (out_emf_offset)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic signed [EMF_W-1:0] clamp_emf(input longint v);
    if (v > EMF_MAX) begin
      return EMF_W'(EMF_MAX);
    end
    if (v < EMF_MIN) begin
      return EMF_W'(EMF_MIN);
    end
    return EMF_W'(v);
  endfunction

  function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_EMF_GAIN: begin
        gain_mirror = data[GAIN_W-1:0];
      end
      CFG_EQUILIBRIUM: begin
        equil_mirror = data[EMF_W-1:0];
      end
      CFG_TAU: begin
        tau_mirror = data[TAU_W-1:0];
      end
      CFG_ENABLE: begin
        enable_mirror = data[0];
      end
      default: begin
      end
    endcase
  endfunction

  function automatic emf_result_t predict_emf(input logic signed [SPD_W-1:0] speed,
                                              input logic [TS_W-1:0] stamp);
    logic [TS_W-1:0] elapsed;
    longint          raw;
    longint          tau_ticks;
    longint          span;
    longint          alpha;
    emf_result_t     res;
    raw = longint'(clamp_emf((longint'(speed) * longint'(gain_mirror)) >>> GAIN_FRAC));
    elapsed = stamp - prev_stamp;
    if (!enable_mirror || !seen_mirror || elapsed == '0) begin
      lowpass_state = EMF_W'(raw);
    end else begin
      if (tau_mirror == '0) begin
        tau_ticks = 1;
      end else begin
        tau_ticks = longint'(tau_mirror);
      end
      span = longint'(elapsed);
      alpha = (span <<< ALPHA_W) / (tau_ticks + span);
      lowpass_state = clamp_emf(longint'(lowpass_state) +
                                ((alpha * (raw - longint'(lowpass_state))) >>> ALPHA_W));
    end
    seen_mirror = 1'b1;
    prev_stamp = stamp;
    res.value = lowpass_state;
    res.offset = OFS_W'(longint'(lowpass_state) - longint'(equil_mirror));
    return res;
  endfunction

  function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.idx = idx;
    r.data = data;
    stimulus_rows.push_back(r);
  endfunction

  function automatic void add_sample(input int speed, input logic [TS_W-1:0] stamp);
    row_t r;
    r = '0;
    r.kind = ROW_SAMPLE;
    r.speed = SPD_W'(speed);
    r.stamp = stamp;
    stimulus_rows.push_back(r);
  endfunction

  function automatic void add_checked(input int speed, input logic [TS_W-1:0] stamp,
                                      input int value, input int offset);
    row_t r;
    r = '0;
    r.kind = ROW_CHECKED;
    r.speed = SPD_W'(speed);
    r.stamp = stamp;
    r.typed.value = EMF_W'(value);
    r.typed.offset = OFS_W'(offset);
    stimulus_rows.push_back(r);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    apply_cfg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [GAIN_W-1:0] gain, input logic [EMF_W-1:0] equil,
                          input logic [TAU_W-1:0] tau, input logic en);
    write_reg(CFG_EMF_GAIN, {8'($urandom), gain});
    write_reg(CFG_EQUILIBRIUM, {4'($urandom), equil});
    write_reg(CFG_TAU, tau);
    write_reg(CFG_ENABLE, {23'($urandom), en});
  endtask

  // the stamp is held until the request is taken
  task automatic offer_sample(input logic signed [SPD_W-1:0] speed,
                              input logic [TS_W-1:0] stamp,
                              input bit typed, input emf_result_t typed_res);
    emf_result_t pred;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      in_speed_sample <= SPD_W'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_speed_sample <= speed;
    in_sample_time <= stamp;
    do @(posedge clk); while (in_stall);
    pred = predict_emf(speed, stamp);
    emf_expected_q.push_back(typed ? typed_res : pred);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (emf_expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input bit with_hold);
    logic signed [SPD_W-1:0] speed;
    logic [TS_W-1:0]         stamp;
    int unsigned             tau_eff;
    int unsigned             pick;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (with_hold && i == PHASE_ITEMS / 4) begin
        hold_off_req = 1'b1;
      end
      tau_eff = (tau_mirror == '0) ? 1 : tau_mirror;
      pick = $urandom_range(99);
      if (pick < 10) begin
        stamp = prev_stamp;
      end else if (pick < 65) begin
        stamp = prev_stamp + $urandom_range(2 * tau_eff, 1);
      end else if (pick < 80) begin
        stamp = prev_stamp + $urandom_range(16, 1);
      end else if (pick < 92) begin
        stamp = $urandom;
      end else begin
        stamp = 32'hFFFF_FF00 + $urandom_range(255);
      end
      pick = $urandom_range(99);
      if (pick < 10) begin
        speed = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      end else if (pick < 25) begin
        speed = SPD_W'(int'($urandom_range(127)) - 64);
      end else begin
        speed = SPD_W'($urandom);
      end
      offer_sample(speed, stamp, 1'b0, '0);
    end
  endtask

  // receiver side: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_off_req) begin
      hold_off_req = 1'b0;
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    emf_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (emf_expected_q.size() == 0) begin
        $display("%0t: result with no request pending, value %0d offset %0d",
                 $time, out_emf_value, out_emf_offset);
        mismatch_count++;
      end else begin
        want = emf_expected_q.pop_front();
        if (out_emf_value !== want.value) begin
          $display("%0t: emf_value mismatch, expected %0d, got %0d",
                   $time, want.value, out_emf_value);
          mismatch_count++;
        end
        if (out_emf_offset !== want.offset) begin
          $display("%0t: emf_offset mismatch, expected %0d, got %0d",
                   $time, want.offset, out_emf_offset);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : drive
    row_t        r;
    emf_result_t typed_res;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_EMF_GAIN;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_speed_sample <= '0;
    in_sample_time <= '0;
    gain_mirror = GAIN_RST;
    equil_mirror = EQUIL_RST;
    tau_mirror = TAU_RST;
    enable_mirror = ENABLE_RST;
    seen_mirror = 1'b0;
    lowpass_state = '0;
    prev_stamp = '0;

    // first sample, then zero elapsed time at both speed extremes
    add_checked(0, 32'd0, 0, 0);
    add_checked(32767, 32'd0, 655, 655);
    add_checked(-32768, 32'd0, -656, -656);
    add_sample(1000, 32'd5000);
    add_sample(-1, 32'd5001);
    // filter off passes the raw value
    add_write(CFG_ENABLE, 24'h000000);
    add_checked(-1, 32'd9000, -1, -1);
    add_write(CFG_EMF_GAIN, 24'h00FFFF);
    add_write(CFG_EQUILIBRIUM, 24'h07FFFF);
    add_checked(32767, 32'd9100, 524264, -23);
    add_checked(-32768, 32'd9200, -524280, -1048567);
    add_write(CFG_EQUILIBRIUM, 24'hF80000);
    add_checked(32767, 32'd9300, 524264, 1048552);
    // zero tau counts as one tick
    add_write(CFG_ENABLE, 24'h000001);
    add_write(CFG_TAU, 24'h000000);
    add_sample(0, 32'd9400);
    add_sample(32767, 32'd9401);
    // slowest filter, timestamp wrap and the longest gap
    add_write(CFG_TAU, 24'hFFFFFF);
    add_sample(-32768, 32'hFFFF_FFF0);
    add_sample(32767, 32'h0000_0010);
    add_sample(100, 32'h0000_000F);
    add_write(CFG_EMF_GAIN, 24'h000000);
    add_sample(12345, 32'h0000_0010);
    add_write(CFG_EMF_GAIN, 24'h001000);
    add_write(CFG_EQUILIBRIUM, 24'h000000);
    add_write(CFG_TAU, 24'd10000);
    add_sample(-20000, 32'h0000_2720);
    add_sample(20000, 32'h0000_4E30);
    add_sample(1, 32'h0000_4E30);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stimulus_rows[k]) begin
      r = stimulus_rows[k];
      case (r.kind)
        ROW_WRITE: begin
          wait_idle();
          write_reg(r.idx, r.data);
        end
        ROW_SAMPLE: begin
          offer_sample(r.speed, r.stamp, 1'b0, '0);
        end
        default: begin
          typed_res = r.typed;
          offer_sample(r.speed, r.stamp, 1'b1, typed_res);
        end
      endcase
    end

    wait_idle();
    set_regs(GAIN_W'($urandom), EMF_W'($urandom), TAU_W'($urandom_range(4000, 1)), 1'b1);
    run_phase(1'b1);

    // a long stretch with no idling on either side
    wait_idle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_regs(16'hFFFF, 20'h80000, 24'hFFFFFF, 1'b1);
    run_phase(1'b0);
    wait_idle();
    tx_idle_pct = IDLE_PCT;
    rx_idle_pct = IDLE_PCT;

    set_regs(GAIN_W'($urandom), 20'h7FFFF, TAU_W'($urandom), 1'b0);
    run_phase(1'b0);

    wait_idle();
    set_regs(GAIN_W'($urandom), EMF_W'($urandom), 24'h000000, 1'b1);
    run_phase(1'b0);

    wait_idle();
    set_regs(GAIN_W'($urandom), EMF_W'($urandom), TAU_W'($urandom_range(20000, 1)),
             1'($urandom));
    run_phase(1'b0);

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && emf_expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
